>>> rtl/bbps_pkg.sv
// Shared types and codes for the bang-bang position servo.
package bbps_pkg;

    localparam int DEF_POS_BITS = 10;
    localparam int NOISE_BITS   = 8;
    localparam int MODE_BITS    = 3;
    localparam int ADDR_BITS    = 5;
    localparam int DATA_BITS    = 32;

    localparam logic [NOISE_BITS-1:0] NOISE_MAX = '1;

    // Register reset values, handed out at the position width or, for the noise limit, at NOISE_BITS
    localparam int RST_NOISE_JUMP  = 50;
    localparam int RST_NOISE_LIMIT = 10;
    localparam int RST_DEADBAND    = 5;

    typedef logic [1:0] drive_t;
    localparam drive_t DRV_RELEASE  = 2'd0;
    localparam drive_t DRV_FORWARD  = 2'd1;
    localparam drive_t DRV_BACKWARD = 2'd2;
    localparam drive_t DRV_BRAKE    = 2'd3;

    typedef logic [MODE_BITS-1:0] mode_t;
    localparam mode_t MODE_TICK     = 3'd0;
    localparam mode_t MODE_MOVE_TO  = 3'd1;
    localparam mode_t MODE_JOG_FWD  = 3'd2;
    localparam mode_t MODE_JOG_BACK = 3'd3;
    localparam mode_t MODE_PARK     = 3'd4;
    localparam mode_t MODE_RELEASE  = 3'd5;
    localparam mode_t MODE_BRAKE    = 3'd6;

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_MIN_POS     = 3'd0;
    localparam reg_idx_t REG_MAX_POS     = 3'd1;
    localparam reg_idx_t REG_PARK_POS    = 3'd2;
    localparam reg_idx_t REG_NOISE_JUMP  = 3'd3;
    localparam reg_idx_t REG_NOISE_LIMIT = 3'd4;
    localparam reg_idx_t REG_DEADBAND    = 3'd5;

    typedef struct packed {
        drive_t drive;
        logic   done_res;
        logic   fault;
    } status_t;

endpackage

>>> rtl/bbps_cfg.sv
// APB register file holding the servo limits and thresholds.
module bbps_cfg #(
    parameter int POS_BITS = bbps_pkg::DEF_POS_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bbps_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [bbps_pkg::DATA_BITS-1:0]      pwdata,
    output logic [bbps_pkg::DATA_BITS-1:0]      prdata,
    output logic                                pready,
    output logic [POS_BITS-1:0]                 min_position,
    output logic [POS_BITS-1:0]                 max_position,
    output logic [POS_BITS-1:0]                 park_position,
    output logic [POS_BITS-1:0]                 noise_jump,
    output logic [bbps_pkg::NOISE_BITS-1:0]     noise_limit,
    output logic [POS_BITS-1:0]                 deadband
);
    import bbps_pkg::*;

    logic [POS_BITS-1:0]   min_reg;
    logic [POS_BITS-1:0]   max_reg;
    logic [POS_BITS-1:0]   park_reg;
    logic [POS_BITS-1:0]   jump_reg;
    logic [NOISE_BITS-1:0] limit_reg;
    logic [POS_BITS-1:0]   dband_reg;
    logic                  wr_en;
    reg_idx_t              idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= '0;
            max_reg   <= '1;
            park_reg  <= '0;
            jump_reg  <= POS_BITS'(RST_NOISE_JUMP);
            limit_reg <= NOISE_BITS'(RST_NOISE_LIMIT);
            dband_reg <= POS_BITS'(RST_DEADBAND);
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_MIN_POS:     min_reg   <= pwdata[POS_BITS-1:0];
                REG_MAX_POS:     max_reg   <= pwdata[POS_BITS-1:0];
                REG_PARK_POS:    park_reg  <= pwdata[POS_BITS-1:0];
                REG_NOISE_JUMP:  jump_reg  <= pwdata[POS_BITS-1:0];
                REG_NOISE_LIMIT: limit_reg <= pwdata[NOISE_BITS-1:0];
                REG_DEADBAND:    dband_reg <= pwdata[POS_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MIN_POS:     prdata = DATA_BITS'(min_reg);
            REG_MAX_POS:     prdata = DATA_BITS'(max_reg);
            REG_PARK_POS:    prdata = DATA_BITS'(park_reg);
            REG_NOISE_JUMP:  prdata = DATA_BITS'(jump_reg);
            REG_NOISE_LIMIT: prdata = DATA_BITS'(limit_reg);
            REG_DEADBAND:    prdata = DATA_BITS'(dband_reg);
            default:         prdata = '0;
        endcase
    end

    assign min_position  = min_reg;
    assign max_position  = max_reg;
    assign park_position = park_reg;
    assign noise_jump    = jump_reg;
    assign noise_limit   = limit_reg;
    assign deadband      = dband_reg;

endmodule

>>> rtl/bbps_core.sv
// Servo state and the per-item decision logic; the state doubles as the result.
module bbps_core #(
    parameter int POS_BITS = bbps_pkg::DEF_POS_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            fire,
    input  bbps_pkg::mode_t                 mode,
    input  logic [POS_BITS-1:0]             sample,
    input  logic [POS_BITS-1:0]             goal,
    input  logic [POS_BITS-1:0]             min_position,
    input  logic [POS_BITS-1:0]             max_position,
    input  logic [POS_BITS-1:0]             park_position,
    input  logic [POS_BITS-1:0]             noise_jump,
    input  logic [bbps_pkg::NOISE_BITS-1:0] noise_limit,
    input  logic [POS_BITS-1:0]             deadband,
    output bbps_pkg::status_t               status,
    output logic [POS_BITS-1:0]             position,
    output logic [POS_BITS-1:0]             aim,
    output logic [POS_BITS-1:0]             gap
);
    import bbps_pkg::*;

    status_t               stat_reg,  stat_next;
    logic [POS_BITS-1:0]   pos_reg,   pos_next;
    logic [POS_BITS-1:0]   aim_reg,   aim_next;
    logic [POS_BITS-1:0]   good_reg,  good_next;
    logic [POS_BITS-1:0]   gap_reg,   gap_next;
    logic [NOISE_BITS-1:0] noise_reg, noise_next;

    logic [POS_BITS-1:0]   clamp_s;
    logic [POS_BITS-1:0]   clamp_g;
    logic [POS_BITS-1:0]   jump_d;
    logic [POS_BITS-1:0]   tgt_dist;

    function automatic logic [POS_BITS-1:0] clamp(
        input logic [POS_BITS-1:0] v,
        input logic [POS_BITS-1:0] lo,
        input logic [POS_BITS-1:0] hi
    );
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [POS_BITS-1:0] abs_diff(
        input logic [POS_BITS-1:0] a,
        input logic [POS_BITS-1:0] b
    );
        return (a >= b) ? a - b : b - a;
    endfunction

    assign clamp_s  = clamp(sample, min_position, max_position);
    assign clamp_g  = clamp(goal, min_position, max_position);
    assign jump_d   = abs_diff(good_reg, sample);
    assign tgt_dist = abs_diff(aim_reg, sample);

    always_comb
    begin
        stat_next  = stat_reg;
        pos_next   = pos_reg;
        aim_next   = aim_reg;
        good_next  = good_reg;
        gap_next   = gap_reg;
        noise_next = noise_reg;
        unique case (mode)
            MODE_TICK:
            begin
                if (stat_reg.drive != DRV_BRAKE)
                begin
                    pos_next = sample;
                    if (noise_reg >= noise_limit)
                    begin
                        stat_next.drive    = DRV_BRAKE;
                        stat_next.done_res = 1'b1;
                        stat_next.fault    = 1'b1;
                        aim_next           = clamp_s;
                        noise_next         = '0;
                    end
                    else if (jump_d >= noise_jump)
                    begin
                        if (noise_reg != NOISE_MAX)
                            noise_next = noise_reg + 1'b1;
                    end
                    else
                    begin
                        gap_next  = tgt_dist;
                        good_next = sample;
                        priority if (sample < min_position)
                            stat_next.drive = DRV_FORWARD;
                        else if (sample > max_position)
                            stat_next.drive = DRV_BACKWARD;
                        else if (tgt_dist < deadband)
                        begin
                            stat_next.drive    = DRV_RELEASE;
                            stat_next.done_res = 1'b1;
                        end
                        else if (sample < aim_reg)
                            stat_next.drive = DRV_FORWARD;
                        else if (sample > aim_reg)
                            stat_next.drive = DRV_BACKWARD;
                        else
                            // on target with a zero deadband: drive left as it is
                            stat_next.drive = stat_reg.drive;
                    end
                end
            end
            MODE_MOVE_TO:
            begin
                aim_next           = clamp_g;
                stat_next.done_res = 1'b0;
                stat_next.drive    = DRV_RELEASE;
            end
            MODE_JOG_FWD:
            begin
                aim_next           = max_position;
                stat_next.done_res = 1'b0;
                stat_next.drive    = DRV_FORWARD;
            end
            MODE_JOG_BACK:
            begin
                aim_next           = min_position;
                stat_next.done_res = 1'b0;
                stat_next.drive    = DRV_BACKWARD;
            end
            MODE_PARK:
            begin
                aim_next           = clamp(park_position, min_position, max_position);
                stat_next.done_res = 1'b0;
                stat_next.drive    = DRV_RELEASE;
            end
            MODE_RELEASE:
            begin
                aim_next           = clamp_s;
                stat_next.done_res = 1'b1;
                stat_next.drive    = DRV_RELEASE;
            end
            MODE_BRAKE:
            begin
                aim_next           = clamp_s;
                stat_next.done_res = 1'b1;
                stat_next.drive    = DRV_BRAKE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stat_reg  <= '{drive: DRV_BRAKE, done_res: 1'b1, fault: 1'b0};
            pos_reg   <= '0;
            aim_reg   <= '0;
            good_reg  <= '0;
            gap_reg   <= '0;
            noise_reg <= '0;
        end
        else if (fire)
        begin
            stat_reg  <= stat_next;
            pos_reg   <= pos_next;
            aim_reg   <= aim_next;
            good_reg  <= good_next;
            gap_reg   <= gap_next;
            noise_reg <= noise_next;
        end
    end

    assign status   = stat_reg;
    assign position = pos_reg;
    assign aim      = aim_reg;
    assign gap      = gap_reg;

endmodule

>>> rtl/bang_bang_position_servo.sv
// Bang-bang position servo: one result per item, one item per clock sustained
// while m_tready stays high. The input register holds the item and
// the servo state registers, updated once per item, form the result register;
// the item is taken into them only when the output side is free, so a new
// item is accepted every cycle while m_tready stays high. Registers are
// written through APB with no wait states and should be changed only while
// no item is in flight.
module bang_bang_position_servo #(
    parameter int POS_BITS = bbps_pkg::DEF_POS_BITS,
    localparam int IN_W    = ((2 * POS_BITS + 7) / 8) * 8,
    localparam int OUT_W   = ((3 * POS_BITS + 4 + 7) / 8) * 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bbps_pkg::ADDR_BITS-1:0] paddr,
    input  logic [bbps_pkg::DATA_BITS-1:0] pwdata,
    output logic [bbps_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [IN_W-1:0]                s_tdata,   // sample, goal, zero fill
    input  bbps_pkg::mode_t                s_tuser,   // mode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [OUT_W-1:0]               m_tdata    // drive, done_res, fault,
                                                      // position, aim, gap, zero fill
);
    import bbps_pkg::*;

    logic                  in_valid_reg, in_valid_next;
    logic                  out_valid_reg, out_valid_next;
    mode_t                 mode_reg;
    logic [POS_BITS-1:0]   sample_reg;
    logic [POS_BITS-1:0]   goal_reg;
    logic                  advance;
    logic                  fire;
    logic                  in_xfer;

    logic [POS_BITS-1:0]   min_position;
    logic [POS_BITS-1:0]   max_position;
    logic [POS_BITS-1:0]   park_position;
    logic [POS_BITS-1:0]   noise_jump;
    logic [NOISE_BITS-1:0] noise_limit;
    logic [POS_BITS-1:0]   deadband;

    status_t               status;
    logic [POS_BITS-1:0]   position;
    logic [POS_BITS-1:0]   aim;
    logic [POS_BITS-1:0]   gap;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign in_xfer  = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_xfer)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mode_reg   <= s_tuser;
            sample_reg <= s_tdata[POS_BITS-1:0];
            goal_reg   <= s_tdata[2*POS_BITS-1:POS_BITS];
        end
    end

    bbps_cfg #(.POS_BITS(POS_BITS)) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .min_position  (min_position),
        .max_position  (max_position),
        .park_position (park_position),
        .noise_jump    (noise_jump),
        .noise_limit   (noise_limit),
        .deadband      (deadband)
    );

    bbps_core #(.POS_BITS(POS_BITS)) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .mode          (mode_reg),
        .sample        (sample_reg),
        .goal          (goal_reg),
        .min_position  (min_position),
        .max_position  (max_position),
        .park_position (park_position),
        .noise_jump    (noise_jump),
        .noise_limit   (noise_limit),
        .deadband      (deadband),
        .status        (status),
        .position      (position),
        .aim           (aim),
        .gap           (gap)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({gap, aim, position, status.fault, status.done_res,
                              status.drive});

endmodule

>>> rtl/bbps_checker.sv
// Port-level checks for the bang-bang position servo, bound to the top level.
module bbps_checker #(
    parameter int POS_BITS = bbps_pkg::DEF_POS_BITS,
    localparam int OUT_W   = ((3 * POS_BITS + 4 + 7) / 8) * 8
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);
    import bbps_pkg::*;

    localparam int FAULT_BIT = 3;

    logic [1:0] occ_reg, occ_next;
    logic       fault_seen_reg, fault_seen_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    always_comb
    begin
        occ_next = occ_reg + 2'(in_xfer) - 2'(out_xfer);
        fault_seen_next = fault_seen_reg || (out_xfer && m_tdata[FAULT_BIT]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg        <= '0;
            fault_seen_reg <= 1'b0;
        end
        else
        begin
            occ_reg        <= occ_next;
            fault_seen_reg <= fault_seen_next;
        end
    end

    // a result never appears without an item behind it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (occ_reg != 2'd0))
        else $error("result shown with no item in flight");

    // at most the input and output registers are occupied
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg != 2'd3)
        else $error("more than two items in flight");

    // noise fault stays set until reset
    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && fault_seen_reg) |-> m_tdata[FAULT_BIT])
        else $error("noise fault cleared without reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind bang_bang_position_servo bbps_checker #(.POS_BITS(POS_BITS)) u_bbps_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> test/tb.sv
// Self-checking testbench for the bang-bang position servo: stream items, APB set-up, scoreboard.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bbps_pkg::*;

    localparam int POS_W      = 10;
    localparam int IN_W       = 24;
    localparam int OUT_W      = 40;
    localparam int IDLE_LIMIT = 2000;

    // mode 7 has no meaning; the servo must leave its state alone
    localparam mode_t MODE_UNUSED = 3'd7;

    typedef logic [POS_W-1:0] pos_t;

    typedef struct {
        drive_t drive;
        logic   done_res;
        logic   fault;
        pos_t   position;
        pos_t   aim;
        pos_t   gap;
    } servo_status_t;

    class servo_scoreboard;
        pos_t           min_pos, max_pos, park_pos, jump_lim, dead_band;
        logic [7:0]     noise_lim;
        drive_t         drv;
        pos_t           cur, tgt, last_good, gap_val;
        logic [7:0]     noise_cnt;
        logic           done_f, fault_f;
        servo_status_t  status_q[$];
        int             errors;
        int             items_seen;
        int             results_seen;

        function new();
            min_pos   = '0;
            max_pos   = '1;
            park_pos  = '0;
            jump_lim  = pos_t'(RST_NOISE_JUMP);
            noise_lim = 8'(RST_NOISE_LIMIT);
            dead_band = pos_t'(RST_DEADBAND);
            drv       = DRV_BRAKE;
            cur       = '0;
            tgt       = '0;
            last_good = '0;
            noise_cnt = '0;
            done_f    = 1'b1;
            fault_f   = 1'b0;
            gap_val   = '0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [31:0] v);
            case (idx)
                REG_MIN_POS:     min_pos   = v[POS_W-1:0];
                REG_MAX_POS:     max_pos   = v[POS_W-1:0];
                REG_PARK_POS:    park_pos  = v[POS_W-1:0];
                REG_NOISE_JUMP:  jump_lim  = v[POS_W-1:0];
                REG_NOISE_LIMIT: noise_lim = v[7:0];
                REG_DEADBAND:    dead_band = v[POS_W-1:0];
                default: ;
            endcase
        endfunction

        function pos_t clamp(pos_t v);
            if (v < min_pos)
                return min_pos;
            if (v > max_pos)
                return max_pos;
            return v;
        endfunction

        function pos_t span_of(pos_t a, pos_t b);
            return (a >= b) ? a - b : b - a;
        endfunction

        function void run_tick(pos_t s);
            if (drv == DRV_BRAKE)
                return;
            cur = s;
            if (noise_cnt >= noise_lim) begin
                tgt       = clamp(s);
                done_f    = 1'b1;
                drv       = DRV_BRAKE;
                fault_f   = 1'b1;
                noise_cnt = '0;
            end
            else if (span_of(last_good, cur) >= jump_lim) begin
                if (noise_cnt != NOISE_MAX)
                    noise_cnt++;
            end
            else begin
                gap_val = span_of(tgt, cur);
                if (cur < min_pos)
                    drv = DRV_FORWARD;
                else if (cur > max_pos)
                    drv = DRV_BACKWARD;
                else if (gap_val < dead_band) begin
                    drv    = DRV_RELEASE;
                    done_f = 1'b1;
                end
                else if (cur < tgt)
                    drv = DRV_FORWARD;
                else if (cur > tgt)
                    drv = DRV_BACKWARD;
                last_good = cur;
            end
        endfunction

        function void note_item(mode_t m, pos_t s, pos_t g);
            servo_status_t st;
            case (m)
                MODE_TICK:    run_tick(s);
                MODE_MOVE_TO: begin tgt = clamp(g); done_f = 1'b0; drv = DRV_RELEASE; end
                MODE_JOG_FWD: begin tgt = max_pos; drv = DRV_FORWARD; done_f = 1'b0; end
                MODE_JOG_BACK: begin tgt = min_pos; drv = DRV_BACKWARD; done_f = 1'b0; end
                MODE_PARK:    begin tgt = clamp(park_pos); done_f = 1'b0; drv = DRV_RELEASE; end
                MODE_RELEASE: begin tgt = clamp(s); done_f = 1'b1; drv = DRV_RELEASE; end
                MODE_BRAKE:   begin tgt = clamp(s); done_f = 1'b1; drv = DRV_BRAKE; end
                default: ;
            endcase
            st.drive    = drv;
            st.done_res = done_f;
            st.fault    = fault_f;
            st.position = cur;
            st.aim      = tgt;
            st.gap      = gap_val;
            status_q.push_back(st);
            items_seen++;
        endfunction

        function void compare_field(string what, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
            end
        endfunction

        function void check_result(logic [OUT_W-1:0] d);
            servo_status_t want;
            results_seen++;
            if (status_q.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result, expected none, got 0x%0h", $time, d);
                return;
            end
            want = status_q.pop_front();
            compare_field("drive",    want.drive,    d[1:0]);
            compare_field("done_res", want.done_res, d[2]);
            compare_field("fault",    want.fault,    d[3]);
            compare_field("position", want.position, d[13:4]);
            compare_field("aim",      want.aim,      d[23:14]);
            compare_field("gap",      want.gap,      d[33:24]);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n    = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [ADDR_BITS-1:0] paddr    = '0;
    logic [DATA_BITS-1:0] pwdata   = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata  = '0;   // sample, goal, zero fill
    mode_t                s_tuser  = MODE_TICK; // mode
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;  // drive, done_res, fault, position, aim, gap, zero fill

    servo_scoreboard sb;
    bit              bursts_on = 1'b0;
    int              walk = 0;
    int              settings_seen = 1;
    int              quiet_cycles = 0;

    bang_bang_position_servo #(.POS_BITS(POS_W)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // input noted before output so a same-edge result still finds its expectation
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_tvalid && s_tready)
                sb.note_item(s_tuser, s_tdata[9:0], s_tdata[19:10]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles <= 0;
        else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == IDLE_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // result side: ready most of the time, stalls in bursts
    initial
    begin
        @(posedge rst_n);
        forever begin
            if (bursts_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    task automatic send_item(mode_t m, pos_t s, pos_t g);
        if (bursts_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= m;
        s_tdata  <= {4'b0, g, s};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // one edge first so the last transfer is already in the queue when it is polled
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.status_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(reg_idx_t idx, logic [31:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.write_reg(idx, v);
    endtask

    task automatic configure(int lo, int hi, int park, int jump, int lim, int band);
        apb_write(REG_MIN_POS, lo);
        apb_write(REG_MAX_POS, hi);
        apb_write(REG_PARK_POS, park);
        apb_write(REG_NOISE_JUMP, jump);
        apb_write(REG_NOISE_LIMIT, lim);
        apb_write(REG_DEADBAND, band);
        settings_seen++;
    endtask

    // sensor follows a random walk; a few readings are wild to provoke noise handling
    task automatic random_items(int n, int step);
        int    k;
        int    w;
        mode_t m;
        pos_t  s;
        pos_t  g;
        for (k = 0; k < n; k++) begin
            g = pos_t'($urandom_range(0, 1023));
            if ($urandom_range(0, 99) < 68) begin
                m = MODE_TICK;
                if ($urandom_range(0, 99) < 8)
                    s = pos_t'($urandom_range(0, 1023));
                else begin
                    w = walk + $urandom_range(0, 2 * step) - step;
                    walk = (w < 0) ? 0 : (w > 1023) ? 1023 : w;
                    s = pos_t'(walk);
                end
            end
            else begin
                m = mode_t'($urandom_range(1, 7));
                s = $urandom_range(0, 1) ? pos_t'(walk) : pos_t'($urandom_range(0, 1023));
                if ($urandom_range(0, 1)) begin
                    w = walk + $urandom_range(0, 16) - 8;
                    g = pos_t'((w < 0) ? 0 : (w > 1023) ? 1023 : w);
                end
            end
            send_item(m, s, g);
        end
    endtask

    initial
    begin
        int lo;
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        bursts_on = 1'b1;

        // reset settings: braked start, unused mode, deadband stop, noise skip, commands
        send_item(MODE_TICK, 512, 0);
        send_item(MODE_UNUSED, 1023, 1023);
        send_item(MODE_RELEASE, 3, 0);
        send_item(MODE_TICK, 3, 0);
        send_item(MODE_MOVE_TO, 0, 1023);
        send_item(MODE_TICK, 40, 0);
        send_item(MODE_TICK, 89, 0);
        send_item(MODE_TICK, 139, 0);
        send_item(MODE_JOG_BACK, 0, 0);
        send_item(MODE_TICK, 60, 0);
        send_item(MODE_TICK, 20, 0);
        send_item(MODE_TICK, 4, 0);
        send_item(MODE_JOG_FWD, 0, 0);
        send_item(MODE_PARK, 0, 0);
        send_item(MODE_BRAKE, 1023, 0);
        send_item(MODE_TICK, 0, 0);
        walk = 4;
        drain();

        // narrow travel, zero deadband, short noise limit leading to a noise brake
        configure(200, 800, 300, 1023, 2, 0);
        send_item(MODE_RELEASE, 100, 0);
        send_item(MODE_TICK, 150, 0);
        send_item(MODE_TICK, 850, 0);
        send_item(MODE_MOVE_TO, 0, 500);
        send_item(MODE_TICK, 500, 0);
        send_item(MODE_MOVE_TO, 0, 1023);
        send_item(MODE_PARK, 0, 0);
        send_item(MODE_TICK, 0, 0);
        send_item(MODE_TICK, 1023, 0);
        send_item(MODE_TICK, 1023, 0);
        send_item(MODE_TICK, 5, 0);
        send_item(MODE_TICK, 700, 0);
        walk = 5;
        random_items(200, 30);
        drain();

        configure(100, 900, 500, 60, 20, 8);
        walk = 500;
        random_items(250, 25);
        drain();

        // inverted limits, zero jump and zero noise limit
        configure(1023, 0, 1023, 0, 0, 1023);
        random_items(150, 10);
        drain();

        configure(0, 1023, 1023, 1023, 255, 1);
        random_items(250, 40);
        drain();

        lo = $urandom_range(0, 1023);
        configure(lo, $urandom_range(lo, 1023), $urandom_range(0, 1023),
                  $urandom_range(20, 300), $urandom_range(1, 40), $urandom_range(1, 30));
        walk = lo;
        random_items(250, 20);
        drain();

        // closing stretch with no idling on either side
        bursts_on = 1'b0;
        configure(0, 1023, 0, 50, 10, 5);
        random_items(250, 20);
        drain();
        repeat (10) @(posedge clk);

        $display("Sent %0d items, checked %0d results across %0d register settings",
                 sb.items_seen, sb.results_seen, settings_seen);
        $display("Settings included inverted limits, zero deadband and noise brakes");
        if (sb.errors == 0 && sb.status_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
